[hw/rtl/dpcl_pkg.sv]
// ----------------------------------------------------------------------------
// dpcl_pkg
// Shared types and constants of the debounced pattern code lock.
// ----------------------------------------------------------------------------
package dpcl_pkg;

  // Pad count and derived widths.
  localparam int NumPads = 5;
  localparam int IdxW    = (NumPads > 1) ? $clog2(NumPads) : 1;
  localparam int LenW    = $clog2(NumPads + 1);

  // Counter and register widths.
  localparam int CntW       = 8;
  localparam int GapW       = 16;
  localparam int HoldW      = 16;
  localparam int CodeLenW   = 3;
  localparam int DigitW     = 3;
  localparam int CodeDigitW = 15;

  // Configuration port.
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Register reset values.
  localparam logic [CntW-1:0]       DebounceRst   = 8'd2;
  localparam logic [GapW-1:0]       GapLimitRst   = 16'd50;
  localparam logic [HoldW-1:0]      HoldRst       = 16'd100;
  localparam logic [CodeLenW-1:0]   CodeLenRst    = 3'd3;
  localparam logic [CodeDigitW-1:0] CodeDigitsRst = 15'd96;

  // Register indexes (byte address divided by four).
  typedef enum logic [2:0] {
    RegDebounce   = 3'd0,
    RegGapLimit   = 3'd1,
    RegHold       = 3'd2,
    RegCodeLen    = 3'd3,
    RegCodeDigits = 3'd4
  } dpcl_reg_e;

  // Lock mode as reported on the result channel.
  typedef enum logic [1:0] {
    ModeEnter   = 2'd0,
    ModeSuccess = 2'd1,
    ModeFail    = 2'd2
  } lock_mode_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [CntW-1:0]       debounce_limit;
    logic [GapW-1:0]       gap_limit;
    logic [HoldW-1:0]      result_hold;
    logic [CodeLenW-1:0]   code_length;
    logic [CodeDigitW-1:0] code_digits;
  } dpcl_cfg_t;

endpackage

[hw/rtl/debounced_pattern_code_lock.sv]
// ----------------------------------------------------------------------------
// debounced_pattern_code_lock
// Touch-pad pattern lock with per-pad debouncing and timed verdict display.
// ----------------------------------------------------------------------------
// The block takes one frame tick per cycle and returns exactly one result per
// tick, in order. A tick is debounced in the front end in the cycle it is
// accepted and written to a two-entry queue; the back end moves it from the
// queue into the result register once that register is free or being taken;
// the result is held there until it is taken with the output not stalled.
// Sustained rate is one tick per cycle, limited only by the output stall.
// Write the configuration registers only while no tick is in flight.
// ----------------------------------------------------------------------------
module debounced_pattern_code_lock
  import dpcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready,
  // Tick input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [NumPads-1:0] raw_pads_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         mode_o,
  output logic [NumPads-1:0] lit_mask_o,
  output logic [NumPads-1:0] clean_mask_o,
  output logic [LenW-1:0]    entered_count_o
);

  dpcl_cfg_t          cfg;
  logic               q_push;
  logic [NumPads-1:0] q_wdata;
  logic               q_pop;
  logic [NumPads-1:0] q_rdata;
  logic               q_valid;
  logic               q_full;

  assign pready = 1'b1;

  // Configuration registers.
  dpcl_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg_o  (cfg)
  );

  // Front end: debounce filter.
  dpcl_filter u_filter (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .raw_pads_i      (raw_pads_i),
    .q_full_i        (q_full),
    .debounce_limit_i(cfg.debounce_limit),
    .in_stall_o      (in_stall_o),
    .push_o          (q_push),
    .clean_o         (q_wdata)
  );

  // Decoupling queue.
  dpcl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  // Back end: path recording and judgment.
  dpcl_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_clean_i      (q_rdata),
    .pop_o          (q_pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .mode_o         (mode_o),
    .lit_mask_o     (lit_mask_o),
    .clean_mask_o   (clean_mask_o),
    .entered_count_o(entered_count_o)
  );

  // The path length always equals the number of lit pads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(lit_mask_o) == 32'(entered_count_o)))
    else $error("path length and lit pads disagree");

  // A verdict is only shown for a non-empty path.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o != ModeEnter)) |-> (entered_count_o != '0))
    else $error("verdict shown with an empty path");

  // A stalled result keeps its slot until taken, so the queue only drains
  // while the result register is free or being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

[hw/rtl/dpcl_regs.sv]
// ----------------------------------------------------------------------------
// dpcl_regs
// APB-style configuration registers of the code lock.
// ----------------------------------------------------------------------------
module dpcl_regs
  import dpcl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output dpcl_cfg_t        cfg_o
);

  dpcl_cfg_t cfg_q;
  dpcl_reg_e reg_idx;
  logic      wr_en;

  assign reg_idx = dpcl_reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register writes; data wider than a register is cut to its width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_limit <= DebounceRst;
      cfg_q.gap_limit      <= GapLimitRst;
      cfg_q.result_hold    <= HoldRst;
      cfg_q.code_length    <= CodeLenRst;
      cfg_q.code_digits    <= CodeDigitsRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDebounce:   cfg_q.debounce_limit <= pwdata[CntW-1:0];
        RegGapLimit:   cfg_q.gap_limit      <= pwdata[GapW-1:0];
        RegHold:       cfg_q.result_hold    <= pwdata[HoldW-1:0];
        RegCodeLen:    cfg_q.code_length    <= pwdata[CodeLenW-1:0];
        RegCodeDigits: cfg_q.code_digits    <= pwdata[CodeDigitW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_idx)
      RegDebounce:   prdata = DataW'(cfg_q.debounce_limit);
      RegGapLimit:   prdata = DataW'(cfg_q.gap_limit);
      RegHold:       prdata = DataW'(cfg_q.result_hold);
      RegCodeLen:    prdata = DataW'(cfg_q.code_length);
      RegCodeDigits: prdata = DataW'(cfg_q.code_digits);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/dpcl_filter.sv]
// ----------------------------------------------------------------------------
// dpcl_filter
// Front end: accepts raw pad ticks and debounces each pad.
// ----------------------------------------------------------------------------
module dpcl_filter
  import dpcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [NumPads-1:0] raw_pads_i,
  input  logic               q_full_i,
  input  logic [CntW-1:0]    debounce_limit_i,
  output logic               in_stall_o,
  output logic               push_o,
  output logic [NumPads-1:0] clean_o
);

  logic [CntW-1:0]    cnt_q [NumPads];
  logic [CntW-1:0]    cnt_d [NumPads];
  logic [NumPads-1:0] clean_q;
  logic [NumPads-1:0] clean_d;
  logic               accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Saturating up/down counter per pad with hysteresis on the clean state.
  always_comb begin
    for (int i = 0; i < NumPads; i++) begin
      cnt_d[i] = cnt_q[i];
      if (raw_pads_i[i]) begin
        if (cnt_q[i] < debounce_limit_i) begin
          cnt_d[i] = cnt_q[i] + 1'b1;
        end
      end else if (cnt_q[i] != '0) begin
        cnt_d[i] = cnt_q[i] - 1'b1;
      end
      clean_d[i] = clean_q[i];
      if (cnt_d[i] == debounce_limit_i) begin
        clean_d[i] = 1'b1;
      end else if (cnt_d[i] == '0) begin
        clean_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPads; i++) begin
        cnt_q[i] <= '0;
      end
      clean_q <= '0;
    end else if (accept) begin
      cnt_q   <= cnt_d;
      clean_q <= clean_d;
    end
  end

  assign push_o  = accept;
  assign clean_o = clean_d;

endmodule

[hw/rtl/dpcl_queue.sv]
// ----------------------------------------------------------------------------
// dpcl_queue
// Two-entry queue of clean pad masks between front and back end.
// ----------------------------------------------------------------------------
module dpcl_queue
  import dpcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [NumPads-1:0] wdata_i,
  input  logic               pop_i,
  output logic [NumPads-1:0] rdata_o,
  output logic               valid_o,
  output logic               full_o
);

  logic [NumPads-1:0] mem_q [2];
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         count_q;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);

endmodule

[hw/rtl/dpcl_judge.sv]
// ----------------------------------------------------------------------------
// dpcl_judge
// Back end: records the pad path, times the gap, judges the code and holds
// the verdict. Its state registers double as the result register.
// ----------------------------------------------------------------------------
module dpcl_judge
  import dpcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpcl_cfg_t          cfg_i,
  input  logic               q_valid_i,
  input  logic [NumPads-1:0] q_clean_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         mode_o,
  output logic [NumPads-1:0] lit_mask_o,
  output logic [NumPads-1:0] clean_mask_o,
  output logic [LenW-1:0]    entered_count_o
);

  lock_mode_e         mode_q, mode_d;
  logic [NumPads-1:0] lit_q, lit_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [GapW-1:0]    gap_q, gap_d;
  logic [HoldW-1:0]   hold_q, hold_d;
  logic [IdxW-1:0]    store_q [NumPads];
  logic [IdxW-1:0]    store_d [NumPads];
  logic [NumPads-1:0] clean_q;
  logic               out_valid_q;

  logic                      any_pressed;
  logic [GapW-1:0]           gap_inc;
  logic                      gap_expired;
  logic                      hold_done;
  logic                      code_ok;
  logic [NumPads*DigitW-1:0] digits_ext;

  // A transaction leaves the queue when the result slot is free or drains.
  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  assign any_pressed = |q_clean_i;
  assign gap_inc     = (gap_q == '1) ? gap_q : gap_q + 1'b1;
  assign gap_expired = (len_q != '0) && (gap_inc > cfg_i.gap_limit);
  assign hold_done   = (hold_q == '0);
  assign digits_ext  = (NumPads*DigitW)'(cfg_i.code_digits);

  // Compare the recorded path with the secret code.
  always_comb begin
    code_ok = (32'(len_q) == 32'(cfg_i.code_length));
    for (int k = 0; k < NumPads; k++) begin
      if (LenW'(k) < len_q) begin
        if (DigitW'(store_q[k]) != digits_ext[k*DigitW +: DigitW]) begin
          code_ok = 1'b0;
        end
      end
    end
  end

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      ModeEnter: begin
        if (!any_pressed && gap_expired) begin
          mode_d = code_ok ? ModeSuccess : ModeFail;
        end
      end
      ModeSuccess, ModeFail: begin
        if (hold_done) begin
          mode_d = ModeEnter;
        end
      end
      default: mode_d = ModeEnter;
    endcase
  end

  // Path, gap and hold updates for the current mode.
  always_comb begin
    lit_d   = lit_q;
    len_d   = len_q;
    gap_d   = gap_q;
    hold_d  = hold_q;
    store_d = store_q;
    if (mode_q == ModeEnter) begin
      if (any_pressed) begin
        gap_d = '0;
        // Append newly pressed pads, lowest index first.
        for (int i = 0; i < NumPads; i++) begin
          if (q_clean_i[i] && !lit_d[i] && (32'(len_d) < NumPads)) begin
            store_d[len_d[IdxW-1:0]] = IdxW'(i);
            len_d                    = len_d + 1'b1;
            lit_d[i]                 = 1'b1;
          end
        end
      end else if (len_q != '0) begin
        if (gap_expired) begin
          gap_d  = '0;
          hold_d = cfg_i.result_hold;
        end else begin
          gap_d = gap_inc;
        end
      end
    end else if (!hold_done) begin
      hold_d = hold_q - 1'b1;
    end else begin
      lit_d = '0;
      len_d = '0;
      gap_d = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeEnter;
      lit_q       <= '0;
      len_q       <= '0;
      gap_q       <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q <= mode_d;
        lit_q  <= lit_d;
        len_q  <= len_d;
        gap_q  <= gap_d;
        hold_q <= hold_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Path entries and the reported clean mask need no reset.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store_q <= store_d;
      clean_q <= q_clean_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = mode_q;
  assign lit_mask_o      = lit_q;
  assign clean_mask_o    = clean_q;
  assign entered_count_o = len_q;

endmodule

[sim/debounced_pattern_code_lock_tb.sv]
// ----------------------------------------------------------------------------
// debounced_pattern_code_lock_tb
// Self-checking bench for the debounced touch-pad pattern lock.
// ----------------------------------------------------------------------------
// Frame ticks are sent on the input channel with random gaps while the result
// channel is stalled at random. A behavioral copy of the lock runs beside the
// block: each accepted tick advances it and queues the view it predicts, and
// every result transaction is compared field by field with the oldest queued
// view. The registers are written over the APB port only after every queued
// view has been matched. Phases cover register access, directed entry of
// right and wrong patterns, code and debounce extremes, a gap window at its
// maximum and a long hold, and random pattern sequences.
// ----------------------------------------------------------------------------
module debounced_pattern_code_lock_tb;
  import dpcl_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int RegSlots   = 8;
  localparam int MaxPrinted = 40;
  localparam int TotalTicks = 900;

  // What one result transaction shows.
  typedef struct packed {
    lock_mode_e           mode;
    logic [NumPads-1:0]   lit;
    logic [NumPads-1:0]   clean;
    logic [LenW-1:0]      count;
  } lock_view_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [NumPads-1:0] raw_pads_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         mode_o;
  logic [NumPads-1:0] lit_mask_o;
  logic [NumPads-1:0] clean_mask_o;
  logic [LenW-1:0]    entered_count_o;

  debounced_pattern_code_lock DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .raw_pads_i      (raw_pads_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mode_o          (mode_o),
    .lit_mask_o      (lit_mask_o),
    .clean_mask_o    (clean_mask_o),
    .entered_count_o (entered_count_o)
  );

  // Bench state: idle rates, counters and the queue of predicted views.
  int unsigned feed_idle_pct   = 14;
  int unsigned drain_stall_pct = 14;
  int unsigned mismatches      = 0;
  int unsigned ticks_sent      = 0;
  int unsigned cycle_count     = 0;
  lock_view_t  pending_views[$];

  // Shadow copy of the lock: configuration and state.
  dpcl_cfg_t          cfg;
  logic [CntW-1:0]    pad_cnt [NumPads];
  logic [NumPads-1:0] pad_clean;
  logic [NumPads-1:0] pad_lit;
  logic [IdxW-1:0]    path_pads [NumPads];
  int                 path_len;
  int                 gap_ticks;
  int                 hold_ticks;
  lock_mode_e         lock_mode;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < drain_stall_pct);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    end
  endtask

  // Compare each result transaction with the oldest predicted view.
  always @(posedge clk_i) begin
    lock_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_views.pop_front();
        if (mode_o != want.mode) report_mismatch("mode", mode_o, want.mode);
        if (lit_mask_o != want.lit) report_mismatch("lit_mask", lit_mask_o, want.lit);
        if (clean_mask_o != want.clean) begin
          report_mismatch("clean_mask", clean_mask_o, want.clean);
        end
        if (entered_count_o != want.count) begin
          report_mismatch("entered_count", entered_count_o, want.count);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Shadow lock
  // ------------------------------------------------------------------------
  function automatic void reset_lock();
    cfg = '{DebounceRst, GapLimitRst, HoldRst, CodeLenRst, CodeDigitsRst};
    for (int i = 0; i < NumPads; i++) begin
      pad_cnt[i]   = '0;
      path_pads[i] = '0;
    end
    pad_clean  = '0;
    pad_lit    = '0;
    path_len   = 0;
    gap_ticks  = 0;
    hold_ticks = 0;
    lock_mode  = ModeEnter;
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [DataW-1:0] value);
    case (idx)
      RegDebounce:   cfg.debounce_limit = value[CntW-1:0];
      RegGapLimit:   cfg.gap_limit      = value[GapW-1:0];
      RegHold:       cfg.result_hold    = value[HoldW-1:0];
      RegCodeLen:    cfg.code_length    = value[CodeLenW-1:0];
      RegCodeDigits: cfg.code_digits    = value[CodeDigitW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [DataW-1:0] register_value(input logic [2:0] idx);
    case (idx)
      RegDebounce:   return DataW'(cfg.debounce_limit);
      RegGapLimit:   return DataW'(cfg.gap_limit);
      RegHold:       return DataW'(cfg.result_hold);
      RegCodeLen:    return DataW'(cfg.code_length);
      RegCodeDigits: return DataW'(cfg.code_digits);
      default:       return '0;
    endcase
  endfunction

  // True when the recorded path equals the secret pattern.
  function automatic bit path_matches_code();
    if (path_len != int'(cfg.code_length)) return 1'b0;
    for (int k = 0; k < path_len; k++) begin
      if (DigitW'(path_pads[k]) != cfg.code_digits[DigitW*k +: DigitW]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the lock by one frame tick and return what it then shows.
  function automatic lock_view_t advance_lock(input logic [NumPads-1:0] raw);
    logic       any_clean;
    lock_view_t view;
    any_clean = 1'b0;
    for (int i = 0; i < NumPads; i++) begin
      if (raw[i]) begin
        if (pad_cnt[i] < cfg.debounce_limit) pad_cnt[i]++;
      end else if (pad_cnt[i] > 0) begin
        pad_cnt[i]--;
      end
      if (pad_cnt[i] == cfg.debounce_limit) pad_clean[i] = 1'b1;
      else if (pad_cnt[i] == 0) pad_clean[i] = 1'b0;
      any_clean |= pad_clean[i];
    end

    if (lock_mode == ModeEnter) begin
      if (any_clean) begin
        // Record newly pressed pads, lowest index first.
        gap_ticks = 0;
        for (int i = 0; i < NumPads; i++) begin
          if (pad_clean[i] && !pad_lit[i] && path_len < NumPads) begin
            path_pads[path_len] = IdxW'(i);
            path_len++;
            pad_lit[i] = 1'b1;
          end
        end
      end else if (path_len > 0) begin
        // Count released ticks; judge once the gap limit is passed.
        if (gap_ticks < 16'hFFFF) gap_ticks++;
        if (gap_ticks > int'(cfg.gap_limit)) begin
          lock_mode  = path_matches_code() ? ModeSuccess : ModeFail;
          hold_ticks = cfg.result_hold;
          gap_ticks  = 0;
        end
      end
    end else if (hold_ticks > 0) begin
      hold_ticks--;
    end else begin
      lock_mode = ModeEnter;
      path_len  = 0;
      gap_ticks = 0;
      pad_lit   = '0;
    end

    view.mode  = lock_mode;
    view.lit   = pad_lit;
    view.clean = pad_clean;
    view.count = LenW'(path_len);
    return view;
  endfunction

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  // Send one frame tick and queue the view it should produce.
  task automatic send_tick(input logic [NumPads-1:0] raw);
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_pads_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    pending_views.push_back(advance_lock(raw));
    ticks_sent++;
  endtask

  task automatic send_ticks(input logic [NumPads-1:0] raw, input int count);
    for (int n = 0; n < count; n++) send_tick(raw);
  endtask

  // Release all pads until the verdict has been shown and the path cleared.
  task automatic settle_verdict();
    int guard;
    guard = 0;
    while ((lock_mode != ModeEnter || path_len != 0) && guard < 140_000) begin
      send_tick('0);
      guard++;
    end
  endtask

  // Stop sending and wait until every predicted view has been matched.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_register(idx, value);
    @(posedge clk_i);
  endtask

  // Read one register back and compare it with the shadow copy.
  task automatic check_register(input logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != register_value(idx)) begin
      report_mismatch($sformatf("register %0d readback", idx), prdata, register_value(idx));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure_lock(input int deb, input int gap, input int hold,
                                input int len, input int digits);
    quiesce();
    apb_write(RegDebounce,   DataW'(deb));
    apb_write(RegGapLimit,   DataW'(gap));
    apb_write(RegHold,       DataW'(hold));
    apb_write(RegCodeLen,    DataW'(len));
    apb_write(RegCodeDigits, DataW'(digits));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Reset values, masking of wide writes, and writes to unused slots.
  task automatic test_register_access();
    for (int idx = RegDebounce; idx <= RegCodeDigits; idx++) check_register(3'(idx));
    apb_write(RegDebounce,   32'hFFFF_FF03);
    apb_write(RegGapLimit,   32'hABCD_0004);
    apb_write(RegHold,       32'h1234_0003);
    apb_write(RegCodeLen,    32'hFFFF_FFF9);
    apb_write(RegCodeDigits, 32'hFFFF_8060);
    for (int idx = RegCodeDigits + 1; idx < RegSlots; idx++) begin
      apb_write(3'(idx), 32'hFFFF_FFFF);
    end
    for (int idx = RegDebounce; idx <= RegCodeDigits; idx++) check_register(3'(idx));
  endtask

  // Right pattern, wrong order, and all pads pressed at once.
  task automatic test_pattern_entry();
    configure_lock(1, 1, 2, 3, 96);
    send_tick(5'b00001);
    send_tick(5'b00000);
    send_tick(5'b10000);
    send_tick(5'b00000);
    send_tick(5'b00010);
    settle_verdict();
    send_tick(5'b10000);
    send_tick(5'b00000);
    send_tick(5'b00001);
    send_tick(5'b00010);
    settle_verdict();
    send_tick(5'b11111);
    settle_verdict();
  endtask

  // Full-length code, empty and oversized lengths, digits naming absent pads.
  task automatic test_code_extremes();
    configure_lock(1, 0, 0, 5, 18056);
    send_tick(5'b11111);
    settle_verdict();
    configure_lock(1, 0, 0, 0, 0);
    send_tick(5'b00001);
    settle_verdict();
    configure_lock(1, 0, 1, 6, 18056);
    send_tick(5'b11111);
    settle_verdict();
    configure_lock(1, 0, 1, 7, 18056);
    send_tick(5'b11111);
    settle_verdict();
    configure_lock(1, 0, 0, 5, 32767);
    send_tick(5'b11111);
    settle_verdict();
    configure_lock(1, 0, 0, 1, 0);
    send_tick(5'b00001);
    settle_verdict();
  endtask

  // Debounce limit of zero, the maximum, a lowered limit, and a short glitch.
  task automatic test_debounce_extremes();
    configure_lock(0, 1, 1, 1, 0);
    send_ticks(5'b00000, 4);
    configure_lock(1, 1, 1, 1, 0);
    settle_verdict();
    configure_lock(255, 1, 1, 1, 2);
    // The slow pad runs with no idling on either side.
    feed_idle_pct   = 0;
    drain_stall_pct = 0;
    send_ticks(5'b00100, 256);
    send_ticks(5'b00000, 256);
    settle_verdict();
    feed_idle_pct   = 14;
    drain_stall_pct = 14;
    configure_lock(20, 1, 1, 1, 3);
    send_ticks(5'b01000, 20);
    configure_lock(5, 1, 1, 1, 3);
    send_ticks(5'b01000, 3);
    send_ticks(5'b00000, 25);
    settle_verdict();
    configure_lock(3, 1, 1, 1, 1);
    send_ticks(5'b00010, 2);
    send_ticks(5'b00000, 2);
    settle_verdict();
  endtask

  // A gap limit at its maximum keeps the path until a new touch; a long hold
  // runs to its end.
  task automatic test_long_windows();
    configure_lock(1, 65535, 30, 2, 8);
    send_tick(5'b00001);
    send_ticks(5'b00000, 40);
    send_tick(5'b00010);
    send_ticks(5'b00000, 20);
    configure_lock(1, 0, 30, 2, 8);
    settle_verdict();
  endtask

  // Random pattern sequences with random timing and code, plus noise bursts.
  task automatic test_random_sequences();
    int          seq;
    int          order [NumPads];
    int          n;
    int          tmp;
    int          j;
    int          deb;
    int          digits;
    logic [NumPads-1:0] glitch;
    seq = 0;
    while (ticks_sent < TotalTicks) begin
      // A stretch of sequences runs with no idling on either side.
      if (seq >= 2 && seq < 5) begin
        feed_idle_pct   = 0;
        drain_stall_pct = 0;
      end else begin
        feed_idle_pct   = 14;
        drain_stall_pct = 14;
      end

      for (int i = 0; i < NumPads; i++) order[i] = i;
      for (int i = NumPads - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      n      = $urandom_range(1, NumPads);
      digits = 0;
      for (int k = 0; k < n; k++) digits |= order[k] << (DigitW * k);

      deb = $urandom_range(1, 4);
      if ($urandom_range(99) < 55) begin
        configure_lock(deb, $urandom_range(0, 6), $urandom_range(0, 5), n, digits);
      end else begin
        configure_lock(deb, $urandom_range(0, 6), $urandom_range(0, 5),
                       $urandom_range(1, NumPads), $urandom_range(0, 32767));
      end

      if ($urandom_range(99) < 15) begin
        for (int t = $urandom_range(5, 20); t > 0; t--) send_tick(NumPads'($urandom));
      end else begin
        for (int k = 0; k < n; k++) begin
          glitch = ($urandom_range(99) < 10) ? NumPads'($urandom) : '0;
          send_tick(NumPads'(1 << order[k]) | glitch);
          send_ticks(NumPads'(1 << order[k]), deb - 1 + $urandom_range(0, 1));
          send_ticks('0, deb + $urandom_range(0, 1));
        end
      end
      settle_verdict();
      seq++;
    end
    feed_idle_pct   = 14;
    drain_stall_pct = 14;
  endtask

  // ------------------------------------------------------------------------
  // Sequence of the run
  // ------------------------------------------------------------------------
  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    raw_pads_i  <= '0;
    out_stall_i <= 1'b0;
    reset_lock();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_pattern_entry();
    test_code_extremes();
    test_debounce_extremes();
    test_long_windows();
    test_random_sequences();

    quiesce();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
